>>> src/scm_pkg.sv
// Package for the solar charge state machine: state type, output codes,
// register indexes and reset values. Used by solar_charge_state_machine.
`default_nettype none
package scm_pkg;

	typedef enum logic [6:0] {
		ST_BOOT      = 7'b0000001,
		ST_SELF_TEST = 7'b0000010,
		ST_IDLE      = 7'b0000100,
		ST_SOLAR     = 7'b0001000,
		ST_CHARGING  = 7'b0010000,
		ST_FULL      = 7'b0100000,
		ST_FAULT     = 7'b1000000
	} state_t;

	localparam logic [2:0] CODE_BOOT      = 3'd0;
	localparam logic [2:0] CODE_SELF_TEST = 3'd1;
	localparam logic [2:0] CODE_IDLE      = 3'd2;
	localparam logic [2:0] CODE_SOLAR     = 3'd3;
	localparam logic [2:0] CODE_CHARGING  = 3'd4;
	localparam logic [2:0] CODE_FULL      = 3'd5;
	localparam logic [2:0] CODE_FAULT     = 3'd6;

	typedef enum logic [2:0] {
		REG_PHASE_DELAY = 3'd0,
		REG_SOLAR_ON    = 3'd1,
		REG_SOLAR_LIMIT = 3'd2,
		REG_SOLAR_LOST  = 3'd3,
		REG_RESUME_SOC  = 3'd4
	} reg_idx_t;

	localparam logic [15:0] PHASE_DELAY_RST = 16'd1500;
	localparam logic [15:0] SOLAR_ON_RST    = 16'd12000;
	localparam logic [15:0] SOLAR_LIMIT_RST = 16'd25000;
	localparam logic [15:0] SOLAR_LOST_RST  = 16'd5000;
	localparam logic [6:0]  RESUME_SOC_RST  = 7'd90;
	localparam logic [6:0]  SOC_FULL        = 7'd100;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        critical_fault;
		logic [6:0]  charge_percent;
		logic [15:0] solar_mv;
	} item_t;

	function automatic logic [2:0] state_code(input state_t s);
		logic [2:0] c;
		begin
			case (s)
				ST_BOOT:      c = CODE_BOOT;
				ST_SELF_TEST: c = CODE_SELF_TEST;
				ST_IDLE:      c = CODE_IDLE;
				ST_SOLAR:     c = CODE_SOLAR;
				ST_CHARGING:  c = CODE_CHARGING;
				ST_FULL:      c = CODE_FULL;
				ST_FAULT:     c = CODE_FAULT;
				default:      c = CODE_BOOT;
			endcase
			return c;
		end
	endfunction

endpackage
`default_nettype wire

>>> src/solar_charge_state_machine.sv
// Solar charge state machine: input register, next-state logic, result register
// and APB register bank. Depends on scm_pkg.
//
//  channel | dir | handshake                 | contents
//  s_      | in  | s_tvalid / s_tready       | solar_mv, charge_percent, critical_fault, now_ms
//  m_      | out | m_tvalid / m_tready       | charge_state, fault_entered
//  apb     | in  | psel & penable & pwrite   | five config registers at 4*i
//
// One word per cycle sustained while the output is not stalled; each result word passes
// through the input register, then the result register.
// The state update happens when a word moves from the input register to the result
// register, so each word sees the state left by the one before it.
// Reset puts the machine in boot with no phase started and loads register defaults.
// A stalled output holds its word; the input register then takes at most one more word and holds it.
`default_nettype none
module solar_charge_state_machine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,   // solar_mv[15:0], charge_percent[22:16],
	                                    // critical_fault[23], now_ms[55:24]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // charge_state[2:0], fault_entered[3], zero pad
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [15:0] phase_delay_q, solar_on_q, solar_limit_q, solar_lost_q;
	logic [6:0]  resume_soc_q;

	scm_pkg::state_t mode_q, mode_d;
	logic [31:0]     phase_start_q, phase_start_d;

	scm_pkg::item_t  item_s1;
	logic            valid_s1;
	logic            adv;
	logic            entered;

	logic [6:0]  soc;
	logic [31:0] elapsed;
	logic        phase_done;
	logic        solar_seen, solar_lost, below_resume, soc_full;
	logic [2:0]  reg_idx;

	// ---------------- config port ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_delay_q <= scm_pkg::PHASE_DELAY_RST;
			solar_on_q    <= scm_pkg::SOLAR_ON_RST;
			solar_limit_q <= scm_pkg::SOLAR_LIMIT_RST;
			solar_lost_q  <= scm_pkg::SOLAR_LOST_RST;
			resume_soc_q  <= scm_pkg::RESUME_SOC_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				scm_pkg::REG_PHASE_DELAY: phase_delay_q <= pwdata[15:0];
				scm_pkg::REG_SOLAR_ON:    solar_on_q    <= pwdata[15:0];
				scm_pkg::REG_SOLAR_LIMIT: solar_limit_q <= pwdata[15:0];
				scm_pkg::REG_SOLAR_LOST:  solar_lost_q  <= pwdata[15:0];
				scm_pkg::REG_RESUME_SOC:  resume_soc_q  <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			scm_pkg::REG_PHASE_DELAY: prdata = {16'd0, phase_delay_q};
			scm_pkg::REG_SOLAR_ON:    prdata = {16'd0, solar_on_q};
			scm_pkg::REG_SOLAR_LIMIT: prdata = {16'd0, solar_limit_q};
			scm_pkg::REG_SOLAR_LOST:  prdata = {16'd0, solar_lost_q};
			scm_pkg::REG_RESUME_SOC:  prdata = {25'd0, resume_soc_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// ---------------- handshake ----------------
	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= s_tdata;
		end
	end

	// ---------------- next state ----------------
	assign soc          = (item_s1.charge_percent > scm_pkg::SOC_FULL) ?
	                      scm_pkg::SOC_FULL : item_s1.charge_percent;
	assign soc_full     = (soc >= scm_pkg::SOC_FULL);
	assign below_resume = (soc < resume_soc_q);
	assign solar_seen   = (item_s1.solar_mv > solar_on_q) && (item_s1.solar_mv < solar_limit_q);
	assign solar_lost   = (item_s1.solar_mv < solar_lost_q);
	assign elapsed      = item_s1.now_ms - phase_start_q;   // wraps mod 2^32
	assign phase_done   = (phase_start_q != 32'd0) && (elapsed > {16'd0, phase_delay_q});

	always_comb begin
		mode_d        = mode_q;
		phase_start_d = phase_start_q;
		entered       = 1'b0;
		if (item_s1.critical_fault) begin
			entered = (mode_q != scm_pkg::ST_FAULT);
			mode_d  = scm_pkg::ST_FAULT;
		end else begin
			case (mode_q)
				scm_pkg::ST_BOOT, scm_pkg::ST_SELF_TEST: begin
					// zero start means not started: record now (a start at 0 records again)
					if (phase_start_q == 32'd0) begin
						phase_start_d = item_s1.now_ms;
					end else if (phase_done) begin
						phase_start_d = 32'd0;
						mode_d = (mode_q == scm_pkg::ST_BOOT) ?
						         scm_pkg::ST_SELF_TEST : scm_pkg::ST_IDLE;
					end
				end
				scm_pkg::ST_IDLE: begin
					if (soc_full)        mode_d = scm_pkg::ST_FULL;
					else if (solar_seen) mode_d = scm_pkg::ST_SOLAR;
				end
				scm_pkg::ST_SOLAR: begin
					if (soc_full)          mode_d = scm_pkg::ST_FULL;
					else if (solar_lost)   mode_d = scm_pkg::ST_IDLE;
					else if (below_resume) mode_d = scm_pkg::ST_CHARGING;
				end
				scm_pkg::ST_CHARGING: begin
					if (soc_full)        mode_d = scm_pkg::ST_FULL;
					else if (solar_lost) mode_d = scm_pkg::ST_IDLE;
				end
				scm_pkg::ST_FULL: begin
					if (below_resume) mode_d = scm_pkg::ST_CHARGING;
				end
				scm_pkg::ST_FAULT: begin
					phase_start_d = 32'd0;
					mode_d        = scm_pkg::ST_BOOT;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= scm_pkg::ST_BOOT;
			phase_start_q <= 32'd0;
		end else if (adv) begin
			mode_q        <= mode_d;
			phase_start_q <= phase_start_d;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {4'd0, entered, scm_pkg::state_code(mode_d)};
		end
	end

	// ---------------- checks ----------------
	a_entered_is_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[2:0] == scm_pkg::CODE_FAULT)
		else $error("fault_entered without fault state");

	a_phase_only_timed: assert property (@(posedge clk) disable iff (!arst_n)
		phase_start_q != 32'd0 |-> (mode_q == scm_pkg::ST_BOOT ||
		mode_q == scm_pkg::ST_SELF_TEST || mode_q == scm_pkg::ST_FAULT))
		else $error("phase start held outside boot, self test or fault");

	a_fault_forces: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.critical_fault |=> mode_q == scm_pkg::ST_FAULT)
		else $error("fault word did not force fault state");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a stalled word");

	a_state_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(mode_q) && $stable(phase_start_q))
		else $error("state changed without a word advancing");

endmodule
`default_nettype wire

>>> verif/solar_charge_state_machine_test.sv
// Self-checking bench for solar_charge_state_machine: directed and random samples
// through the stream ports, register writes over APB, state predicted in the bench.
// Depends on scm_pkg and solar_charge_state_machine.
module solar_charge_state_machine_test;

	typedef struct {
		logic [2:0] code;
		logic       entered;
	} charge_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// predictor state and register mirror
	logic [2:0]  cur_mode = scm_pkg::CODE_BOOT;
	logic [31:0] phase_start = 32'd0;
	logic [15:0] cfg_delay = scm_pkg::PHASE_DELAY_RST;
	logic [15:0] cfg_on = scm_pkg::SOLAR_ON_RST;
	logic [15:0] cfg_limit = scm_pkg::SOLAR_LIMIT_RST;
	logic [15:0] cfg_lost = scm_pkg::SOLAR_LOST_RST;
	logic [6:0]  cfg_resume = scm_pkg::RESUME_SOC_RST;

	scm_pkg::item_t sample_q[$];
	charge_result_t state_due_q[$];
	int unsigned    mismatch_count = 0;
	int unsigned    words_in = 0;
	logic [31:0]    stamp = 32'd0;
	bit             word_taken = 1'b0;
	bit             send_gaps = 1'b1;
	bit             stall_on = 1'b1;
	bit             hold_off = 1'b0;
	int unsigned    gap_left = 0;
	int unsigned    stall_left = 0;

	solar_charge_state_machine dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),   // solar_mv, charge_percent, critical_fault, now_ms
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),   // charge_state, fault_entered, zero pad
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned pick_gap(input bit enable);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!enable || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// boot / self test timer; a start stamped at zero reads as not started
	function automatic bit phase_timer_expired(input logic [31:0] now);
		logic [31:0] elapsed;
		elapsed = now - phase_start;
		if (phase_start == 32'd0) begin
			phase_start = now;
			return 1'b0;
		end
		if (elapsed > {16'd0, cfg_delay}) begin
			phase_start = 32'd0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic charge_result_t advance_charge_state(input scm_pkg::item_t smp);
		logic [6:0]     soc;
		logic [2:0]     nxt;
		charge_result_t res;
		soc = (smp.charge_percent > scm_pkg::SOC_FULL) ? scm_pkg::SOC_FULL :
		      smp.charge_percent;
		nxt = cur_mode;
		res.entered = 1'b0;
		if (smp.critical_fault) begin
			res.entered = (cur_mode != scm_pkg::CODE_FAULT);
			nxt = scm_pkg::CODE_FAULT;
		end else begin
			case (cur_mode)
				scm_pkg::CODE_BOOT: begin
					if (phase_timer_expired(smp.now_ms))
						nxt = scm_pkg::CODE_SELF_TEST;
				end
				scm_pkg::CODE_SELF_TEST: begin
					if (phase_timer_expired(smp.now_ms))
						nxt = scm_pkg::CODE_IDLE;
				end
				scm_pkg::CODE_IDLE: begin
					if (soc >= scm_pkg::SOC_FULL)
						nxt = scm_pkg::CODE_FULL;
					else if (smp.solar_mv > cfg_on && smp.solar_mv < cfg_limit)
						nxt = scm_pkg::CODE_SOLAR;
				end
				scm_pkg::CODE_SOLAR: begin
					if (soc >= scm_pkg::SOC_FULL)
						nxt = scm_pkg::CODE_FULL;
					else if (smp.solar_mv < cfg_lost)
						nxt = scm_pkg::CODE_IDLE;
					else if (soc < cfg_resume)
						nxt = scm_pkg::CODE_CHARGING;
				end
				scm_pkg::CODE_CHARGING: begin
					if (soc >= scm_pkg::SOC_FULL)
						nxt = scm_pkg::CODE_FULL;
					else if (smp.solar_mv < cfg_lost)
						nxt = scm_pkg::CODE_IDLE;
				end
				scm_pkg::CODE_FULL: begin
					if (soc < cfg_resume)
						nxt = scm_pkg::CODE_CHARGING;
				end
				scm_pkg::CODE_FAULT: begin
					// fault gone: restart at boot, timer cleared, no timing this word
					phase_start = 32'd0;
					nxt = scm_pkg::CODE_BOOT;
				end
				default: begin
				end
			endcase
		end
		cur_mode = nxt;
		res.code = nxt;
		return res;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// sender
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !word_taken) begin
			end else if (gap_left != 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (sample_q.size() != 0) begin
				s_tdata <= sample_q.pop_front();
				s_tvalid <= 1'b1;
				gap_left <= pick_gap(send_gaps);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_off) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			stall_left <= pick_gap(stall_on);
		end
	end

	// monitor: register writes, accepted samples, returned words
	always @(posedge clk) begin
		charge_result_t due;
		if (arst_n) begin
			word_taken <= s_tvalid && s_tready;
			if (psel && penable && pwrite && pready) begin
				case (scm_pkg::reg_idx_t'(paddr[4:2]))
					scm_pkg::REG_PHASE_DELAY: cfg_delay = pwdata[15:0];
					scm_pkg::REG_SOLAR_ON:    cfg_on = pwdata[15:0];
					scm_pkg::REG_SOLAR_LIMIT: cfg_limit = pwdata[15:0];
					scm_pkg::REG_SOLAR_LOST:  cfg_lost = pwdata[15:0];
					scm_pkg::REG_RESUME_SOC:  cfg_resume = pwdata[6:0];
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				state_due_q.push_back(advance_charge_state(scm_pkg::item_t'(s_tdata)));
				words_in++;
			end
			if (m_tvalid && m_tready) begin
				if (state_due_q.size() == 0) begin
					flag_mismatch($sformatf("word %h with nothing due", m_tdata));
				end else begin
					due = state_due_q.pop_front();
					if (m_tdata[2:0] !== due.code)
						flag_mismatch($sformatf("charge_state %0d, want %0d",
							m_tdata[2:0], due.code));
					if (m_tdata[3] !== due.entered)
						flag_mismatch($sformatf("fault_entered %b, want %b",
							m_tdata[3], due.entered));
				end
			end
		end
	end

	task automatic add_sample(input logic [15:0] solar, input logic [6:0] soc,
		input logic fault, input logic [31:0] now);
		scm_pkg::item_t s;
		s.solar_mv = solar;
		s.charge_percent = soc;
		s.critical_fault = fault;
		s.now_ms = now;
		sample_q.push_back(s);
	endtask

	// every sample yields one word, so drained means nothing queued or due
	task automatic wait_drained();
		@(negedge clk);
		while (sample_q.size() != 0 || s_tvalid || state_due_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input scm_pkg::reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_config(input logic [15:0] delay, input logic [15:0] on_mv,
		input logic [15:0] limit_mv, input logic [15:0] lost_mv, input logic [6:0] resume);
		wait_drained();
		write_reg(scm_pkg::REG_PHASE_DELAY, {16'd0, delay});
		write_reg(scm_pkg::REG_SOLAR_ON, {16'd0, on_mv});
		write_reg(scm_pkg::REG_SOLAR_LIMIT, {16'd0, limit_mv});
		write_reg(scm_pkg::REG_SOLAR_LOST, {16'd0, lost_mv});
		write_reg(scm_pkg::REG_RESUME_SOC, {25'd0, resume});
	endtask

	// mostly a running clock so boot and self test complete; thresholds probed closely
	function automatic scm_pkg::item_t make_sample();
		scm_pkg::item_t s;
		int unsigned    r;
		logic [15:0]    nudge;
		nudge = 16'($urandom_range(0, 2));
		r = $urandom_range(0, 99);
		if (r >= 90)
			stamp = $urandom;
		else if (r >= 80)
			stamp = stamp + cfg_delay;
		else if (r >= 70)
			stamp = stamp + cfg_delay + 1;
		else if (r >= 10)
			stamp = stamp + $urandom_range(1, cfg_delay / 2 + 20);
		s.now_ms = stamp;
		r = $urandom_range(0, 99);
		if (r < 15)
			s.solar_mv = cfg_on + nudge - 16'd1;
		else if (r < 25)
			s.solar_mv = cfg_limit + nudge - 16'd1;
		else if (r < 40)
			s.solar_mv = cfg_lost + nudge - 16'd1;
		else if (r < 45)
			s.solar_mv = 16'd0;
		else if (r < 50)
			s.solar_mv = 16'hFFFF;
		else
			s.solar_mv = 16'($urandom_range(0, 65535));
		r = $urandom_range(0, 99);
		if (r < 20) begin
			s.charge_percent = cfg_resume + nudge[6:0] - 7'd1;
		end else if (r < 35) begin
			case ($urandom_range(0, 3))
				0: s.charge_percent = 7'd99;
				1: s.charge_percent = 7'd100;
				2: s.charge_percent = 7'd101;
				default: s.charge_percent = 7'd127;
			endcase
		end else begin
			s.charge_percent = 7'($urandom_range(0, 127));
		end
		s.critical_fault = ($urandom_range(0, 99) < 4);
		return s;
	endfunction

	initial begin
		logic [15:0] on_mv;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// boot timing from reset values, including a start stamped at zero
		add_sample(16'd0, 7'd0, 1'b0, 32'd0);
		add_sample(16'd0, 7'd0, 1'b0, 32'd100);
		add_sample(16'd0, 7'd0, 1'b0, 32'd1600);
		add_sample(16'd0, 7'd0, 1'b0, 32'd1601);
		add_sample(16'd0, 7'd0, 1'b0, 32'd2000);
		// fault mid self test, held, then cleared back to boot
		add_sample(16'd0, 7'd0, 1'b1, 32'd2100);
		add_sample(16'd0, 7'd0, 1'b1, 32'd2150);
		add_sample(16'd0, 7'd0, 1'b0, 32'd2200);
		// elapsed time across the 32-bit wrap
		add_sample(16'd0, 7'd0, 1'b0, 32'hFFFF_FF00);
		add_sample(16'd0, 7'd0, 1'b0, 32'h0000_0500);
		add_sample(16'd0, 7'd0, 1'b0, 32'h0000_0600);
		add_sample(16'd0, 7'd0, 1'b0, 32'hFFFF_FFFF);
		// charge above 100 saturates
		add_sample(16'hFFFF, 7'd127, 1'b0, 32'd1);
		add_sample(16'd0, 7'd89, 1'b0, 32'd2);
		add_sample(16'd4999, 7'd50, 1'b0, 32'd3);
		add_sample(16'd12000, 7'd50, 1'b0, 32'd4);
		add_sample(16'd12001, 7'd50, 1'b0, 32'd5);
		add_sample(16'd20000, 7'd95, 1'b0, 32'd6);
		add_sample(16'd20000, 7'd50, 1'b0, 32'd7);
		add_sample(16'd20000, 7'd100, 1'b0, 32'd8);

		// resume above 100 makes full and charging alternate; zero delay
		set_config(16'd0, 16'd0, 16'hFFFF, 16'd0, 7'd127);
		add_sample(16'd30000, 7'd100, 1'b0, 32'd9);
		add_sample(16'd30000, 7'd100, 1'b0, 32'd10);
		add_sample(16'd30000, 7'd100, 1'b1, 32'd11);
		add_sample(16'd30000, 7'd100, 1'b0, 32'd12);
		add_sample(16'd30000, 7'd100, 1'b0, 32'd7);
		add_sample(16'd30000, 7'd100, 1'b0, 32'd7);
		add_sample(16'd30000, 7'd100, 1'b0, 32'd8);

		stamp = $urandom;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					set_config(scm_pkg::PHASE_DELAY_RST, scm_pkg::SOLAR_ON_RST,
						scm_pkg::SOLAR_LIMIT_RST, scm_pkg::SOLAR_LOST_RST,
						scm_pkg::RESUME_SOC_RST);
					send_gaps = 1'b1;
					stall_on = 1'b1;
				end
				1: begin
					set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, scm_pkg::SOC_FULL);
					send_gaps = 1'b0;
					stall_on = 1'b0;
				end
				2: begin
					set_config(16'd0, 16'd0, 16'd0, 16'd0, 7'd0);
					send_gaps = 1'b1;
					stall_on = 1'b0;
				end
				3: begin
					on_mv = 16'($urandom_range(2000, 30000));
					set_config(16'($urandom_range(0, 3000)), on_mv,
						on_mv + 16'($urandom_range(1, 20000)),
						16'($urandom_range(0, on_mv)),
						7'($urandom_range(0, 100)));
					send_gaps = 1'b0;
					stall_on = 1'b1;
				end
				default: begin
					set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
						16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
						7'($urandom_range(0, 127)));
					send_gaps = 1'b1;
					stall_on = 1'b1;
				end
			endcase
			repeat (146)
				sample_q.push_back(make_sample());
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && state_due_q.size() == 0)
			$display("solar_charge_state_machine verification clean");
		else
			$display("solar_charge_state_machine verification failed");
		$finish;
	end

	// long receiver hold-off while the sender keeps offering words
	initial begin
		while (words_in < 420)
			@(posedge clk);
		hold_off = 1'b1;
		repeat (80) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		#2000000;
		$display("solar_charge_state_machine verification failed");
		$finish;
	end

endmodule

>>> solar_charge_state_machine.f
src/scm_pkg.sv
src/solar_charge_state_machine.sv
verif/solar_charge_state_machine_test.sv
